### design/swds_pkg.sv
package swds_pkg;

  localparam int unsigned STEPS_PER_REV_DEF = 2048;
  localparam int unsigned MAX_DEGREES_DEF   = 360;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned STEP_W   = 12;
  localparam int unsigned ANGLE_W  = 10;
  localparam int unsigned COIL_W   = 4;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [PERIOD_W-1:0] CW_PERIOD_RST  = 16'd6;
  localparam logic [PERIOD_W-1:0] CCW_PERIOD_RST = 16'd4;
  localparam logic [COIL_W-1:0]   COILS_OFF      = 4'hF;

  typedef enum logic {
    OP_ROTATE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    DIR_CW    = 2'd0,
    DIR_CCW   = 2'd1,
    DIR_BAD_A = 2'd2,
    DIR_BAD_B = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DIR   = 2'd1,
    ST_BAD_ANGLE = 2'd2,
    ST_BUSY      = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CW_PERIOD  = 1'b0,
    REG_CCW_PERIOD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic               op;
    logic [1:0]         direction;
    logic [ANGLE_W-1:0] angle;
  } swds_in_t;

  typedef struct packed {
    logic [COIL_W-1:0] coils;
    logic              busy_res;
    logic [1:0]        status;
  } swds_out_t;

  // active-low wave drive pattern for one step of a run
  function automatic logic [COIL_W-1:0] phase_coil(input logic ccw, input logic [1:0] idx);
    logic [1:0] bit_sel;
    bit_sel = ccw ? idx : 2'(2'd3 - idx);
    return ~(COIL_W'(1) << bit_sel);
  endfunction

endpackage

### design/swds_scale.sv
module swds_scale #(
  parameter int unsigned STEPS_PER_REV = swds_pkg::STEPS_PER_REV_DEF,
  parameter int unsigned MAX_DEGREES   = swds_pkg::MAX_DEGREES_DEF
) (
  input  logic [swds_pkg::ANGLE_W-1:0] angle,
  output logic [swds_pkg::STEP_W-1:0]  steps
);
  import swds_pkg::*;

  // floor(angle * STEPS_PER_REV / MAX_DEGREES), clamped to STEP_MAX, as one multiply by a rounded-up reciprocal
  localparam int unsigned    SCALE_SHIFT = ANGLE_W * 2;
  localparam longint unsigned RECIP =
    ((longint'(STEPS_PER_REV) << SCALE_SHIFT) + longint'(MAX_DEGREES) - 1) /
    longint'(MAX_DEGREES);
  localparam int unsigned RECIP_W = $clog2(RECIP + 1);
  localparam int unsigned PROD_W  = ANGLE_W + RECIP_W;
  localparam int unsigned QUOT_W  = PROD_W - SCALE_SHIFT;
  localparam logic [STEP_W-1:0] STEP_MAX = '1;

  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;

  assign prod  = PROD_W'(angle) * PROD_W'(RECIP);
  assign quot  = prod[PROD_W-1:SCALE_SHIFT];
  assign steps = (quot > QUOT_W'(STEP_MAX)) ? STEP_MAX : STEP_W'(quot);

endmodule

### design/stepper_wave_drive_sequencer.sv
// An accepted input beat is held in the input register, its result beat in the
// result register. Throughput: one beat per cycle; one pass of logic between the input
// register and the result register, stalls propagate back in the same cycle.
// Reset (rst_n low, synchronous): idle, coils all off, periods 6 (cw) and 4 (ccw),
// both stage registers empty.
module stepper_wave_drive_sequencer #(
  parameter int unsigned STEPS_PER_REV = swds_pkg::STEPS_PER_REV_DEF,
  parameter int unsigned MAX_DEGREES   = swds_pkg::MAX_DEGREES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  swds_pkg::swds_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output swds_pkg::swds_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [swds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swds_pkg::PERIOD_W-1:0]  cfg_wdata
);
  import swds_pkg::*;

  logic                in_valid_r;
  swds_in_t            in_data_r;
  logic                out_valid_r;
  swds_out_t           out_data_r, out_nxt;

  logic [PERIOD_W-1:0] cw_period_r, ccw_period_r;

  logic                running_r, running_nxt;
  logic [STEP_W-1:0]   step_total_r, step_total_nxt;
  logic [STEP_W-1:0]   step_index_r, step_index_nxt;
  logic [PERIOD_W-1:0] hold_count_r, hold_count_nxt;
  logic                run_dir_r, run_dir_nxt;
  logic [COIL_W-1:0]   coil_drive_r, coil_drive_nxt;

  logic                adv, in_take, fire;
  logic [STEP_W-1:0]   steps;
  logic [PERIOD_W-1:0] period, hold_inc;
  logic [STEP_W-1:0]   index_inc;
  status_t             status;

  swds_scale #(
    .STEPS_PER_REV (STEPS_PER_REV),
    .MAX_DEGREES   (MAX_DEGREES)
  ) u_scale (
    .angle (in_data_r.angle),
    .steps (steps)
  );

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;
  assign fire     = in_valid_r && adv;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    period = run_dir_r ? ccw_period_r : cw_period_r;
    if (period == '0) begin
      period = PERIOD_W'(1);
    end
    hold_inc  = hold_count_r + PERIOD_W'(1);
    index_inc = step_index_r + STEP_W'(1);

    running_nxt    = running_r;
    step_total_nxt = step_total_r;
    step_index_nxt = step_index_r;
    hold_count_nxt = hold_count_r;
    run_dir_nxt    = run_dir_r;
    coil_drive_nxt = coil_drive_r;
    status         = ST_OK;

    if (in_data_r.op == OP_ROTATE) begin
      if (running_r) begin
        status = ST_BUSY;
      end else if (in_data_r.angle > ANGLE_W'(MAX_DEGREES)) begin
        status = ST_BAD_ANGLE;
      end else begin
        coil_drive_nxt = COILS_OFF;
        if (!(in_data_r.direction inside {DIR_CW, DIR_CCW})) begin
          status = ST_BAD_DIR;
        end else begin
          step_total_nxt = steps;
          step_index_nxt = '0;
          hold_count_nxt = '0;
          run_dir_nxt    = (in_data_r.direction == DIR_CCW);
          running_nxt    = (steps != '0);
        end
      end
    end else if (running_r) begin
      if (hold_count_r == '0) begin
        coil_drive_nxt = phase_coil(run_dir_r, step_index_r[1:0]);
      end
      hold_count_nxt = hold_inc;
      if (hold_inc >= period || hold_inc == '0) begin
        hold_count_nxt = '0;
        step_index_nxt = index_inc;
        if (index_inc >= step_total_r) begin
          running_nxt = 1'b0;
        end
      end
    end

    out_nxt.coils    = coil_drive_nxt;
    out_nxt.busy_res = running_nxt;
    out_nxt.status   = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      cw_period_r  <= CW_PERIOD_RST;
      ccw_period_r <= CCW_PERIOD_RST;
      running_r    <= 1'b0;
      step_total_r <= '0;
      step_index_r <= '0;
      hold_count_r <= '0;
      run_dir_r    <= 1'b0;
      coil_drive_r <= COILS_OFF;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r  <= 1'b1;
        running_r    <= running_nxt;
        step_total_r <= step_total_nxt;
        step_index_r <= step_index_nxt;
        hold_count_r <= hold_count_nxt;
        run_dir_r    <= run_dir_nxt;
        coil_drive_r <= coil_drive_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CW_PERIOD:  cw_period_r  <= cfg_wdata;
          REG_CCW_PERIOD: ccw_period_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= out_nxt;
    end
  end

endmodule
